[design/text_console_number_formatter_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text console number formatter
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_NUMBER_FORMATTER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_NUMBER_FORMATTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside reset
`define TCNF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tcnf assertion failed");

// condition that must never be true outside reset
`define TCNF_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tcnf forbidden condition seen");

`else

`define TCNF_ASSERT(label, prop)
`define TCNF_NEVER(label, cond)

`endif

`endif

[design/tcnf_pkg.sv]
// ----------------------------------------------------------------------------
// tcnf_pkg
// Types, codes and character helpers of the text console number formatter.
// ----------------------------------------------------------------------------
package tcnf_pkg;

   // input item kinds
   localparam logic [2:0] MODE_CHAR  = 3'd0;
   localparam logic [2:0] MODE_HEX8  = 3'd1;
   localparam logic [2:0] MODE_HEX16 = 3'd2;
   localparam logic [2:0] MODE_HEX32 = 3'd3;
   localparam logic [2:0] MODE_DEC8  = 3'd4;
   localparam logic [2:0] MODE_DEC16 = 3'd5;
   localparam logic [2:0] MODE_DEC32 = 3'd6;
   localparam logic [2:0] MODE_HOME  = 3'd7;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;   // 'A' - 10
   localparam logic [7:0] ATTR_RESET     = 8'h0F;

   localparam int          CELL_IDX_W = 11;
   localparam int          DIG_W      = 40;         // ten BCD nibbles
   localparam int          BCD_DIGITS = 10;
   localparam logic [3:0]  DEC_MAX_DIGITS = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } st_type;

   // ASCII of one hex or decimal digit
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] ext;
      ext = {4'b0000, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + ext;
      end
      return HEX_ALPHA_BASE + ext;
   endfunction

endpackage

[design/text_console_number_formatter_core.sv]
// ----------------------------------------------------------------------------
// text_console_number_formatter_core
// Turns character, hex and decimal print requests into text-cell writes.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: req_tuser carries the mode, req_tdata the value. One item
//  prints one character, 2/4/8 hex digits or an unsigned decimal number, or
//  moves the cursor (newline, home). rsp_ channel: one item per cell write,
//  rsp_tlast marks the last cell of a request. csr_ sets the attribute byte.
//  Flow: the block takes one request at a time and is not ready until
//  its last cell has been loaded into the output register. A character
//  request emits one cell and a hex request one cell per digit. A decimal
//  request runs a double-dabble shift loop over 8, 16 or 32 bits (dec8,
//  dec16, dec32), then drops leading zeros but always keeps the final
//  digit, then emits one cell per digit of up to ten BCD digits. Newline
//  and home produce no cell. Each cell is registered in the output register.
//  A stalled receiver holds the output register; digit emission waits.
//  Reset clears the cursor to row 0, column 0 and the attribute to 0x0F.
// ----------------------------------------------------------------------------
`include "text_console_number_formatter_core_defines.svh"

module text_console_number_formatter_core #(
   parameter int LINE_WIDTH  = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] mode
   // cell write item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] cell_index, [26:11] cell_word, [31:27] zero
   output logic        rsp_tlast,   // last
   // attribute register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // text_attribute
);
   import tcnf_pkg::*;

   localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int COL_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
   localparam int IDX_W = $clog2(SCREEN_ROWS * LINE_WIDTH);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);

   st_type            state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [7:0]        attr_ff;
   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic [31:0]       bin_ff, bin_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [3:0]        rem_ff, rem_in;
   logic              is_char_ff, is_char_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [26:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              load_out;
   logic              emit_last;
   logic [DIG_W-1:0]  dabbled;
   logic [7:0]        cell_char;
   logic [IDX_W-1:0]  cell_idx;
   logic              row_wrap;
   logic [ROW_W-1:0]  row_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign load_out   = !rsp_valid_ff || rsp_tready;
   assign emit_last  = (state_ff == ST_EMIT) && load_out && (rem_ff == 4'd1);

   // add-3 correction on every BCD nibble before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            dabbled[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            dabbled[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   assign cell_char = is_char_ff ? dig_ff[DIG_W-1 -: 8] : digit_char(dig_ff[DIG_W-1 -: 4]);
   assign cell_idx  = IDX_W'(row_ff) * IDX_W'(LINE_WIDTH) + IDX_W'(col_ff);
   assign row_wrap  = (row_ff == ROW_LAST);
   assign row_next  = row_wrap ? '0 : row_ff + ROW_W'(1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      dig_in       = dig_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      is_char_in   = is_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_char_in = 1'b0;
               dig_in     = '0;
               unique case (req_tuser)
                  MODE_CHAR: begin
                     if (req_tdata[7:0] == CHAR_NEWLINE) begin
                        col_in = '0;
                        row_in = row_next;
                     end else begin
                        dig_in     = {req_tdata[7:0], 32'h0};
                        is_char_in = 1'b1;
                        rem_in     = 4'd1;
                        state_in   = ST_EMIT;
                     end
                  end
                  MODE_HEX8: begin
                     dig_in   = {req_tdata[7:0], 32'h0};
                     rem_in   = 4'd2;
                     state_in = ST_EMIT;
                  end
                  MODE_HEX16: begin
                     dig_in   = {req_tdata[15:0], 24'h0};
                     rem_in   = 4'd4;
                     state_in = ST_EMIT;
                  end
                  MODE_HEX32: begin
                     dig_in   = {req_tdata, 8'h0};
                     rem_in   = 4'd8;
                     state_in = ST_EMIT;
                  end
                  MODE_DEC8: begin
                     bin_in   = {req_tdata[7:0], 24'h0};
                     cnt_in   = 6'd8;
                     rem_in   = DEC_MAX_DIGITS;
                     state_in = ST_CONV;
                  end
                  MODE_DEC16: begin
                     bin_in   = {req_tdata[15:0], 16'h0};
                     cnt_in   = 6'd16;
                     rem_in   = DEC_MAX_DIGITS;
                     state_in = ST_CONV;
                  end
                  MODE_DEC32: begin
                     bin_in   = req_tdata;
                     cnt_in   = 6'd32;
                     rem_in   = DEC_MAX_DIGITS;
                     state_in = ST_CONV;
                  end
                  MODE_HOME: begin
                     row_in = '0;
                     col_in = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            dig_in = {dabbled[DIG_W-2:0], bin_ff[31]};
            bin_in = {bin_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, always keep the final digit
            if (dig_ff[DIG_W-1 -: 4] == 4'd0 && rem_ff > 4'd1) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'h0};
               rem_in = rem_ff - 4'd1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {attr_ff, cell_char, CELL_IDX_W'(cell_idx)};
               rsp_last_in  = emit_last;
               dig_in       = {dig_ff[DIG_W-5:0], 4'h0};
               rem_in       = rem_ff - 4'd1;
               if (col_ff == COL_LAST) begin
                  col_in = '0;
                  row_in = row_next;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      bin_ff      <= bin_in;
      is_char_ff  <= is_char_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `TCNF_ASSERT(a_cursor_range, (col_ff <= COL_LAST) && (row_ff <= ROW_LAST))
   `TCNF_NEVER(a_emit_digits, (state_ff == ST_EMIT || state_ff == ST_SKIP) && rem_ff == 4'd0)
   `TCNF_NEVER(a_conv_count, (state_ff == ST_CONV) && (cnt_ff == 6'd0))
   `TCNF_ASSERT(a_last_ends, emit_last |=> (state_ff == ST_IDLE && rsp_tvalid && rsp_tlast))

endmodule
